FILE: hw/rtl/lirg_pkg.sv
// Shared types, constants and helpers for the linear interpolation resampler.
// Used by lirg_front, lirg_queue, lirg_back and linear_interp_resampler_gain.
// No dependencies.
package lirg_pkg;

   // Frame geometry
   localparam int MAX_CHANNELS = 8;
   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCH_W = $clog2(MAX_CHANNELS + 1);

   // Phase accumulator fixed point
   localparam int PHASE_FRAC_BITS = 16;

   // Field and register widths
   localparam int SAMPLE_W = 16;
   localparam int OUT_CH_W = 3;
   localparam int COUNT_W = 4;
   localparam int STEP_W = 24;
   localparam int GAIN_W = 16;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;

   // Results one beat may cause
   localparam int RESULT_LIMIT = 64;
   localparam int RES_W = $clog2(RESULT_LIMIT + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // One in phase units, and the smallest step honored (one eighth)
   localparam logic [STEP_W:0] PHASE_ONE = {{STEP_W{1'b0}}, 1'b1} << PHASE_FRAC_BITS;
   localparam logic [STEP_W:0] STEP_MIN = PHASE_ONE >> 3;

   // Output saturation magnitude
   localparam int SAT_MAX = 32767;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT   = 2'd0,
      CSR_RESAMPLE_ENABLE = 2'd1,
      CSR_PHASE_STEP      = 2'd2,
      CSR_GAIN_LINEAR     = 2'd3
   } csr_index_type;

   // What the back end does with one accepted sample
   typedef enum logic [1:0] {
      CMD_BYPASS = 2'd0,   // pass the sample through
      CMD_STORE  = 2'd1,   // write it into the current frame
      CMD_FRAME  = 2'd2,   // write it, frame complete, no history yet
      CMD_RUN    = 2'd3    // write it, frame complete, interpolate
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [SAMPLE_W-1:0]   sample;
      logic [CH_W-1:0]       chan;
      logic                  end_mark;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    channel_count;
      logic                  resample_enable;
      logic [STEP_W-1:0]     phase_step;
      logic [GAIN_W-1:0]     gain_linear;
   } cfg_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EMIT = 1'b1
   } bk_state_type;

   // Channel count as used: zero counts as one, large values saturate.
   function automatic logic [NCH_W-1:0] clamp_channels(input logic [COUNT_W-1:0] cnt);
      logic [NCH_W-1:0] res;
      if (cnt == '0) begin
         res = NCH_W'(1);
      end else if (int'(cnt) > MAX_CHANNELS) begin
         res = NCH_W'(MAX_CHANNELS);
      end else begin
         res = NCH_W'(cnt);
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/lirg_front.sv
// Front end: accepts input beats, tracks the channel position and frame history
// flag, and turns each beat into a command for the back end. Uses lirg_pkg.
module lirg_front (
   input  logic                             clock,
   input  logic                             reset,
   input  lirg_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [lirg_pkg::SAMPLE_W-1:0] req_pcm_in,
   input  logic                             req_end_of_recording,
   input  logic                             q_full,
   output logic                             push,
   output lirg_pkg::cmd_type                push_cmd
);

   logic [lirg_pkg::CH_W-1:0]    chpos_ff, chpos_in;
   logic                         have_prev_ff, have_prev_in;
   logic [lirg_pkg::NCH_W-1:0]   nch;
   logic [lirg_pkg::CH_W-1:0]    pos;
   logic [lirg_pkg::NCH_W:0]     pos_plus;
   logic                         wrap;
   logic                         complete;
   logic                         accept;

   // Classify the beat against the current position.
   always_comb begin
      nch       = lirg_pkg::clamp_channels(cfg.channel_count);
      pos       = (int'(chpos_ff) >= lirg_pkg::MAX_CHANNELS) ? '0 : chpos_ff;
      pos_plus  = (lirg_pkg::NCH_W + 1)'(pos) + 1'b1;
      wrap      = (pos_plus >= {1'b0, nch});
      complete  = cfg.resample_enable && wrap;
      accept    = req_valid && !q_full;
      req_stall = q_full;
      push      = accept;

      push_cmd.sample   = req_pcm_in;
      push_cmd.chan     = pos;
      push_cmd.end_mark = req_end_of_recording;
      if (!cfg.resample_enable) begin
         push_cmd.kind = lirg_pkg::CMD_BYPASS;
      end else if (!complete) begin
         push_cmd.kind = lirg_pkg::CMD_STORE;
      end else if (have_prev_ff) begin
         push_cmd.kind = lirg_pkg::CMD_RUN;
      end else begin
         push_cmd.kind = lirg_pkg::CMD_FRAME;
      end
   end

   // Position and history flag advance on each accepted beat; the end mark clears them.
   always_comb begin
      chpos_in     = chpos_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         if (req_end_of_recording) begin
            chpos_in     = '0;
            have_prev_in = 1'b0;
         end else begin
            chpos_in = wrap ? '0 : lirg_pkg::CH_W'(pos_plus);
            if (complete) begin
               have_prev_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chpos_ff     <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         chpos_ff     <= chpos_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

FILE: hw/rtl/lirg_queue.sv
// Short command queue that decouples the front end from the back end.
// Uses lirg_pkg for the command type and depth.
module lirg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lirg_pkg::cmd_type     push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output lirg_pkg::cmd_type     head_cmd
);

   lirg_pkg::cmd_type               mem_ff [lirg_pkg::QUEUE_DEPTH];
   logic [lirg_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lirg_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [lirg_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_push, do_pop;

   // Pointer and fill bookkeeping.
   always_comb begin
      full       = (count_ff == lirg_pkg::QCNT_W'(lirg_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = mem_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == lirg_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == lirg_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The front end never offers a command while the queue is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("command pushed into a full queue");

   // The fill count stays within the depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= lirg_pkg::QUEUE_DEPTH)
      else $error("queue fill count out of range");

endmodule

FILE: hw/rtl/lirg_back.sv
// Back end: frame buffers, phase accumulator and emit sequencer, followed by the
// interpolation and gain pipeline and the output register. Uses lirg_pkg.
module lirg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lirg_pkg::cfg_type                     cfg,
   input  logic                                  head_valid,
   input  lirg_pkg::cmd_type                     head_cmd,
   output logic                                  pop,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [lirg_pkg::SAMPLE_W-1:0]  rsp_pcm_out,
   output logic [lirg_pkg::OUT_CH_W-1:0]         rsp_out_channel,
   output logic                                  rsp_last_of_run
);

   localparam int FB = lirg_pkg::PHASE_FRAC_BITS;
   localparam int SW = lirg_pkg::SAMPLE_W;
   localparam int PROD_W = FB + SW + 2;
   localparam int NUM_W = PROD_W + 1;
   localparam int GP_W = lirg_pkg::GAIN_W + 1 + SW;
   localparam int GQ_W = GP_W - 8;
   localparam int BSUM_W = lirg_pkg::RES_W + 2;
   localparam logic signed [GQ_W-1:0] SAT_HI = GQ_W'(lirg_pkg::SAT_MAX);
   localparam logic signed [GQ_W-1:0] SAT_LO = -SAT_HI;

   // Sequencer state
   lirg_pkg::bk_state_type            state_ff, state_in;
   logic [lirg_pkg::STEP_W-1:0]       rp_ff, rp_in;
   logic [lirg_pkg::CH_W-1:0]         emit_ch_ff, emit_ch_in;
   logic [lirg_pkg::RES_W-1:0]        base_ff, base_in;

   // Frame history
   logic [SW-1:0]                     prev_ff [lirg_pkg::MAX_CHANNELS];
   logic [SW-1:0]                     cur_ff  [lirg_pkg::MAX_CHANNELS];

   // Sequencer helpers
   logic [lirg_pkg::NCH_W-1:0]        nch;
   logic                              adv;
   logic [lirg_pkg::STEP_W:0]         step_eff;
   logic [lirg_pkg::STEP_W:0]         rp_ext;
   logic [lirg_pkg::STEP_W:0]         rp_sum;
   logic [lirg_pkg::STEP_W:0]         rp_stop;
   logic [lirg_pkg::STEP_W:0]         rp_drop;
   logic                              rp_below;
   logic                              iter_end;
   logic [BSUM_W-1:0]                 base_next;
   logic                              limit_hit;
   logic                              run_done;

   // Sequencer controls
   logic                              cur_we;
   logic [lirg_pkg::CH_W-1:0]         cur_wch;
   logic [SW-1:0]                     cur_wdata;
   logic                              copy;
   logic                              issue;
   logic                              issue_byp;
   logic [SW-1:0]                     issue_a;
   logic [SW-1:0]                     issue_b;
   logic [lirg_pkg::CH_W-1:0]         issue_ch;
   logic                              issue_last;
   logic signed [SW:0]                issue_diff;

   // Stage 1: operands
   logic                              s1_valid_ff;
   logic                              s1_byp_ff, s1_last_ff;
   logic [lirg_pkg::CH_W-1:0]         s1_ch_ff;
   logic [SW-1:0]                     s1_a_ff;
   logic signed [SW:0]                s1_diff_ff;
   logic [FB-1:0]                     s1_frac_ff;
   // Stage 2: fraction product
   logic                              s2_valid_ff;
   logic                              s2_byp_ff, s2_last_ff;
   logic [lirg_pkg::CH_W-1:0]         s2_ch_ff;
   logic [SW-1:0]                     s2_a_ff;
   logic signed [PROD_W-1:0]          s2_prod_ff, s2_prod_in;
   // Stage 3: interpolated sample
   logic                              s3_valid_ff;
   logic                              s3_last_ff;
   logic [lirg_pkg::CH_W-1:0]         s3_ch_ff;
   logic signed [SW-1:0]              s3_y_ff, s3_y_in;
   logic [NUM_W-1:0]                  num, num_adj;
   // Stage 4: gain product
   logic                              s4_valid_ff;
   logic                              s4_last_ff;
   logic [lirg_pkg::CH_W-1:0]         s4_ch_ff;
   logic signed [SW-1:0]              s4_y_ff;
   logic signed [GP_W-1:0]            s4_g_ff, s4_g_in;
   // Output register
   logic                              rsp_valid_ff;
   logic                              rsp_last_ff;
   logic [lirg_pkg::OUT_CH_W-1:0]     rsp_ch_ff;
   logic signed [SW-1:0]              rsp_pcm_ff, rsp_pcm_in;
   logic [GP_W-1:0]                   g_adj;
   logic signed [GQ_W-1:0]            g_q;

   // Phase arithmetic and loop bounds.
   always_comb begin
      nch       = lirg_pkg::clamp_channels(cfg.channel_count);
      adv       = !rsp_valid_ff || !rsp_stall;
      step_eff  = ({1'b0, cfg.phase_step} < lirg_pkg::STEP_MIN) ?
                  lirg_pkg::STEP_MIN : {1'b0, cfg.phase_step};
      rp_ext    = {1'b0, rp_ff};
      rp_sum    = rp_ext + step_eff;
      rp_below  = (rp_ext < lirg_pkg::PHASE_ONE);
      rp_stop   = (rp_sum >= lirg_pkg::PHASE_ONE) ? rp_sum : lirg_pkg::PHASE_ONE;
      rp_drop   = rp_ext - lirg_pkg::PHASE_ONE;
      iter_end  = ((lirg_pkg::NCH_W + 1)'(emit_ch_ff) + 1'b1) >= {1'b0, nch};
      base_next = BSUM_W'(base_ff) + BSUM_W'(nch);
      limit_hit = (base_next + BSUM_W'(nch)) > BSUM_W'(lirg_pkg::RESULT_LIMIT);
      run_done  = iter_end && ((rp_sum >= lirg_pkg::PHASE_ONE) || limit_hit);
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lirg_pkg::BK_IDLE: begin
            if (head_valid && (head_cmd.kind == lirg_pkg::CMD_RUN) && rp_below) begin
               state_in = lirg_pkg::BK_EMIT;
            end
         end
         lirg_pkg::BK_EMIT: begin
            if (adv && run_done) begin
               state_in = lirg_pkg::BK_IDLE;
            end
         end
         default: state_in = lirg_pkg::BK_IDLE;
      endcase
   end

   // Sequencer outputs: buffer writes, issue into the pipeline, phase updates.
   always_comb begin
      pop        = 1'b0;
      cur_we     = 1'b0;
      cur_wch    = head_cmd.chan;
      cur_wdata  = head_cmd.sample;
      copy       = 1'b0;
      issue      = 1'b0;
      issue_byp  = 1'b0;
      issue_a    = head_cmd.sample;
      issue_b    = head_cmd.sample;
      issue_ch   = head_cmd.chan;
      issue_last = 1'b0;
      rp_in      = rp_ff;
      emit_ch_in = emit_ch_ff;
      base_in    = base_ff;
      unique case (state_ff)
         lirg_pkg::BK_IDLE: begin
            if (head_valid) begin
               unique case (head_cmd.kind)
                  lirg_pkg::CMD_BYPASS: begin
                     if (adv) begin
                        issue      = 1'b1;
                        issue_byp  = 1'b1;
                        issue_last = 1'b1;
                        pop        = 1'b1;
                        if (head_cmd.end_mark) begin
                           rp_in = '0;
                        end
                     end
                  end
                  lirg_pkg::CMD_STORE: begin
                     cur_we = 1'b1;
                     pop    = 1'b1;
                     if (head_cmd.end_mark) begin
                        rp_in = '0;
                     end
                  end
                  lirg_pkg::CMD_FRAME: begin
                     cur_we = 1'b1;
                     copy   = 1'b1;
                     pop    = 1'b1;
                     if (head_cmd.end_mark) begin
                        rp_in = '0;
                     end
                  end
                  lirg_pkg::CMD_RUN: begin
                     cur_we     = 1'b1;
                     emit_ch_in = '0;
                     base_in    = '0;
                     // Position already at or past one: this frame is skipped.
                     if (!rp_below) begin
                        copy  = 1'b1;
                        pop   = 1'b1;
                        rp_in = head_cmd.end_mark ? '0 : lirg_pkg::STEP_W'(rp_drop);
                     end
                  end
                  default: ;
               endcase
            end
         end
         lirg_pkg::BK_EMIT: begin
            if (adv) begin
               issue      = 1'b1;
               issue_a    = prev_ff[emit_ch_ff];
               issue_b    = cur_ff[emit_ch_ff];
               issue_ch   = emit_ch_ff;
               issue_last = run_done;
               if (iter_end) begin
                  emit_ch_in = '0;
                  base_in    = lirg_pkg::RES_W'(base_next);
                  rp_in      = lirg_pkg::STEP_W'(rp_sum);
                  if (run_done) begin
                     copy  = 1'b1;
                     pop   = 1'b1;
                     rp_in = head_cmd.end_mark ? '0 :
                             lirg_pkg::STEP_W'(rp_stop - lirg_pkg::PHASE_ONE);
                  end
               end else begin
                  emit_ch_in = emit_ch_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
      issue_diff = {issue_b[SW-1], issue_b} - {issue_a[SW-1], issue_a};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lirg_pkg::BK_IDLE;
         rp_ff      <= '0;
         emit_ch_ff <= '0;
         base_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rp_ff      <= rp_in;
         emit_ch_ff <= emit_ch_in;
         base_ff    <= base_in;
      end
   end

   // Frame buffers; the history copy covers only the active channels.
   always_ff @(posedge clock) begin
      for (int i = 0; i < lirg_pkg::MAX_CHANNELS; i++) begin
         if (cur_we && (lirg_pkg::CH_W'(i) == cur_wch)) begin
            cur_ff[i] <= cur_wdata;
         end
         if (copy && (i < int'(nch))) begin
            prev_ff[i] <= (cur_we && (lirg_pkg::CH_W'(i) == cur_wch)) ? cur_wdata : cur_ff[i];
         end
      end
   end

   // Datapath: fraction product, truncation toward zero, gain product, saturation.
   always_comb begin
      s2_prod_in = $signed({1'b0, s1_frac_ff}) * s1_diff_ff;

      num     = {{(NUM_W - SW - FB){s2_a_ff[SW-1]}}, s2_a_ff, {FB{1'b0}}}
                + {s2_prod_ff[PROD_W-1], s2_prod_ff};
      num_adj = num + {{(NUM_W - FB){1'b0}}, {FB{num[NUM_W-1]}}};
      s3_y_in = s2_byp_ff ? s2_a_ff : num_adj[FB+SW-1:FB];

      s4_g_in = $signed({1'b0, cfg.gain_linear}) * s3_y_ff;

      g_adj = s4_g_ff + {{(GP_W - 8){1'b0}}, {8{s4_g_ff[GP_W-1]}}};
      g_q   = g_adj[GP_W-1:8];
      if (cfg.gain_linear == '0) begin
         rsp_pcm_in = s4_y_ff;
      end else if (g_q > SAT_HI) begin
         rsp_pcm_in = SW'(SAT_HI);
      end else if (g_q < SAT_LO) begin
         rsp_pcm_in = SW'(SAT_LO);
      end else begin
         rsp_pcm_in = SW'(g_q);
      end
   end

   // Pipeline valid bits; the whole pipe holds while the output register is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_byp_ff   <= issue_byp;
         s1_last_ff  <= issue_last;
         s1_ch_ff    <= issue_ch;
         s1_a_ff     <= issue_a;
         s1_diff_ff  <= issue_diff;
         s1_frac_ff  <= rp_ff[FB-1:0];

         s2_byp_ff   <= s1_byp_ff;
         s2_last_ff  <= s1_last_ff;
         s2_ch_ff    <= s1_ch_ff;
         s2_a_ff     <= s1_a_ff;
         s2_prod_ff  <= s2_prod_in;

         s3_last_ff  <= s2_last_ff;
         s3_ch_ff    <= s2_ch_ff;
         s3_y_ff     <= s3_y_in;

         s4_last_ff  <= s3_last_ff;
         s4_ch_ff    <= s3_ch_ff;
         s4_y_ff     <= s3_y_ff;
         s4_g_ff     <= s4_g_in;

         rsp_last_ff <= s4_last_ff;
         rsp_ch_ff   <= lirg_pkg::OUT_CH_W'(s4_ch_ff);
         rsp_pcm_ff  <= rsp_pcm_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pcm_out     = rsp_pcm_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // The emit channel never runs past the active channel count.
   a_emit_ch_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lirg_pkg::BK_EMIT) |-> (lirg_pkg::NCH_W'(emit_ch_ff) < nch))
      else $error("emit channel beyond channel count");

   // Interpolation is only issued with a fractional position below one.
   a_issue_phase_below_one: assert property (@(posedge clock) disable iff (reset)
      (issue && !issue_byp) |-> rp_below)
      else $error("interpolation issued with position at or above one");

   // A command leaves the queue only when one is present.
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   // The per-beat result count stays within its limit.
   a_base_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(base_ff) <= lirg_pkg::RESULT_LIMIT)
      else $error("result count above limit");

endmodule

FILE: hw/rtl/linear_interp_resampler_gain.sv
// Top level of the linear interpolation resampler with output gain.
// Holds the control registers and connects lirg_front, lirg_queue and lirg_back.
// Depends on lirg_pkg.
//
// Usage:
//   req_* carries one interleaved 16-bit sample per beat (valid/stall); the
//   end-of-recording flag marks the last sample and clears position and history.
//   rsp_* carries result beats: sample, channel index, and a flag on the last
//   result caused by one input beat. csr_* writes the four control registers
//   (channel count, resample enable, phase step, gain) while the block is idle.
// Timing:
//   In bypass every input beat yields one result, and beats stream at one per
//   cycle while rsp_stall does not hold the pipe. With resampling on, a beat that
//   closes a frame is followed by k*N result beats, one per cycle unless stalled
//   (N channels, k phase steps below one, at most 64 results); other beats only
//   write the frame buffer and do not hold the back end. The emit sequencer,
//   which issues one channel per cycle when not stalled, sets this figure.
// Reset clears the control registers to their defaults and empties the queue
// and the pipeline. On rsp_stall with a valid result the pipe holds; the two-entry
// command queue keeps accepting input beats until it fills, then raises req_stall.
module linear_interp_resampler_gain (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lirg_pkg::SAMPLE_W-1:0]   req_pcm_in,
   input  logic                                   req_end_of_recording,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lirg_pkg::SAMPLE_W-1:0]   rsp_pcm_out,
   output logic [lirg_pkg::OUT_CH_W-1:0]          rsp_out_channel,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_we,
   input  logic [lirg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lirg_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   lirg_pkg::cfg_type   cfg_ff;
   logic                q_full;
   logic                push;
   lirg_pkg::cmd_type   push_cmd;
   logic                pop;
   logic                head_valid;
   lirg_pkg::cmd_type   head_cmd;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count   <= lirg_pkg::COUNT_W'(1);
         cfg_ff.resample_enable <= 1'b0;
         cfg_ff.phase_step      <= lirg_pkg::STEP_W'(lirg_pkg::PHASE_ONE);
         cfg_ff.gain_linear     <= '0;
      end else if (csr_we) begin
         unique case (lirg_pkg::csr_index_type'(csr_index))
            lirg_pkg::CSR_CHANNEL_COUNT:
               cfg_ff.channel_count <= csr_wdata[lirg_pkg::COUNT_W-1:0];
            lirg_pkg::CSR_RESAMPLE_ENABLE:
               cfg_ff.resample_enable <= csr_wdata[0];
            lirg_pkg::CSR_PHASE_STEP:
               cfg_ff.phase_step <= csr_wdata[lirg_pkg::STEP_W-1:0];
            lirg_pkg::CSR_GAIN_LINEAR:
               cfg_ff.gain_linear <= csr_wdata[lirg_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   lirg_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pcm_in           (req_pcm_in),
      .req_end_of_recording (req_end_of_recording),
      .q_full               (q_full),
      .push                 (push),
      .push_cmd             (push_cmd)
   );

   lirg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lirg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pcm_out     (rsp_pcm_out),
      .rsp_out_channel (rsp_out_channel),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
